// ===== rtl/sph_pkg.sv =====
// Shared types and constants for the state pair histogram.
`timescale 1ns / 1ps
package sph_pkg;

  localparam int MAX_STATES     = 32;
  localparam int MAX_CATEGORIES = 8;
  localparam int ST_DEPTH       = MAX_CATEGORIES * MAX_STATES * MAX_STATES;
  localparam int ADDR_W         = $clog2(ST_DEPTH);
  localparam int COUNT_W        = 32;
  localparam int WEIGHT_W       = 20;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;

  typedef enum logic [1:0] {
    REQ_ACC   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NOP   = 2'd3
  } req_e_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_UNKNOWN  = 2'd1,
    STAT_RANGE    = 2'd2,
    STAT_CATEGORY = 2'd3
  } status_e_t;

  localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_CODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CATEGORIES = 2'd2;

  typedef struct packed {
    logic [5:0] state_count;
    logic [7:0] unknown_code;
    logic [3:0] num_categories;
  } cfg_t;

  typedef struct packed {
    status_e_t         status;
    logic [ADDR_W-1:0] addr;
  } loc_t;

endpackage

// ===== rtl/state_pair_histogram.sv =====
// Top level of the state pair histogram: control, configuration and result register.
`timescale 1ns / 1ps
// Weighted joint histogram of state pairs kept in one 8192 x 32 memory, one plane of
// MAX_STATES x MAX_STATES counters per rate category. Every input transaction gives
// exactly one result transaction. For accumulate and read transactions the accept edge
// issues the memory read; the result step then adds the weight (saturating at 2^32-1),
// writes the entry back and loads the result register. in_ready is low until that
// result step is done, so a new transaction is taken only after the last one finishes.
// The result register lets the next transaction be accepted while a result still waits;
// a transaction that reaches its result step while the register is full holds there.
// A clear transaction sweeps all 8192 entries of the memory one entry a cycle, then
// gives its result in the following result step. After reset the same clearing pass
// runs with in_ready low;
// configuration writes are taken at any time and should only be issued while idle.
module state_pair_histogram (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_req_type,
  input  logic [7:0]                          in_state_a,
  input  logic [7:0]                          in_state_b,
  input  logic [sph_pkg::WEIGHT_W-1:0]        in_weight,
  input  logic signed [3:0]                   in_category,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic [sph_pkg::COUNT_W-1:0]         out_entry_value,
  output logic                                out_saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sph_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sph_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sph_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CALC  = 3'b010,
    S_CLEAR = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  cfg_t               cfg_r;
  loc_t               loc;
  req_e_t             op_r;
  status_e_t          status_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               init_r, init_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r;
  logic [COUNT_W-1:0] out_value_r;
  logic               out_sat_r;

  logic               in_fire;
  logic               slot_free;
  logic               finish;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] res_value;
  logic               res_sat;
  logic               acc_we;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic [COUNT_W-1:0] ram_rdata;

  // Configuration: always ready, the write lands at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.state_count    <= 6'd4;
      cfg_r.unknown_code   <= 8'd255;
      cfg_r.num_categories <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STATE_COUNT:    cfg_r.state_count    <= cfg_data[5:0];
        CFG_UNKNOWN_CODE:   cfg_r.unknown_code   <= cfg_data;
        CFG_NUM_CATEGORIES: cfg_r.num_categories <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  sph_locate u_locate (
    .req_type (in_req_type),
    .state_a  (in_state_a),
    .state_b  (in_state_b),
    .category (in_category),
    .cfg      (cfg_r),
    .loc      (loc)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Capture the transaction; the memory read goes out on the same edge.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= req_e_t'(in_req_type);
      status_r <= loc.status;
      addr_r   <= loc.addr;
      weight_r <= in_weight;
    end
  end

  // Result step: add and clamp, or pass the read value through.
  always_comb begin
    sum       = {1'b0, ram_rdata} + (COUNT_W + 1)'(weight_r);
    res_value = '0;
    res_sat   = 1'b0;
    acc_we    = 1'b0;
    case (op_r)
      REQ_ACC: begin
        if (status_r == STAT_DONE) begin
          res_sat   = sum[COUNT_W];
          res_value = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
          acc_we    = 1'b1;
        end
      end
      REQ_READ: begin
        if (status_r == STAT_DONE) begin
          res_value = ram_rdata;
        end
      end
      default: ;
    endcase
  end

  // Sequencer: idle, result step, clearing sweep.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    init_nxt    = init_r;
    finish      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = addr_r;
    ram_wdata   = res_value;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (req_e_t'(in_req_type) == REQ_CLEAR) begin
            clr_cnt_nxt = '0;
            state_nxt   = S_CLEAR;
          end else begin
            state_nxt = S_CALC;
          end
        end
      end
      S_CALC: begin
        // hold until the result register can take the result
        if (slot_free) begin
          finish    = 1'b1;
          ram_we    = acc_we;
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(ST_DEPTH - 1)) begin
          // the sweep after reset returns to idle with no result
          init_nxt  = 1'b0;
          state_nxt = init_r ? S_IDLE : S_CALC;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      init_r    <= 1'b1;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      init_r    <= init_nxt;
    end
  end

  sph_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (loc.addr),
    .rdata (ram_rdata)
  );

  // Result register: set on finish, drop once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status_r <= status_r;
      out_value_r  <= res_value;
      out_sat_r    <= res_sat;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_value = out_value_r;
  assign out_saturated   = out_sat_r;

endmodule

// ===== rtl/sph_ram.sv =====
// Single write port, single read port histogram memory with registered read data.
`timescale 1ns / 1ps
module sph_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [sph_pkg::ADDR_W-1:0]    waddr,
  input  logic [sph_pkg::COUNT_W-1:0]   wdata,
  input  logic                          re,
  input  logic [sph_pkg::ADDR_W-1:0]    raddr,
  output logic [sph_pkg::COUNT_W-1:0]   rdata
);
  import sph_pkg::*;

  logic [COUNT_W-1:0] mem_r [ST_DEPTH];
  logic [COUNT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  assign rdata = rd_data_r;

endmodule

// ===== rtl/sph_locate.sv =====
// Request checks and store address computation.
`timescale 1ns / 1ps
module sph_locate (
  input  logic [1:0]    req_type,
  input  logic [7:0]    state_a,
  input  logic [7:0]    state_b,
  input  logic [3:0]    category,
  input  sph_pkg::cfg_t cfg,
  output sph_pkg::loc_t loc
);
  import sph_pkg::*;

  logic [8:0] ns_eff;
  logic [4:0] nc_eff;
  logic [2:0] cat_sel;
  logic       unknown_hit;
  logic       range_bad;
  logic       cat_bad;
  req_e_t     req;

  always_comb begin
    req     = req_e_t'(req_type);
    ns_eff  = (9'(cfg.state_count) > 9'(MAX_STATES)) ? 9'(MAX_STATES) : 9'(cfg.state_count);
    nc_eff  = (5'(cfg.num_categories) > 5'(MAX_CATEGORIES)) ?
              5'(MAX_CATEGORIES) : 5'(cfg.num_categories);
    // negative category folds onto plane zero
    cat_sel     = category[3] ? 3'd0 : category[2:0];
    unknown_hit = (state_a == cfg.unknown_code) || (state_b == cfg.unknown_code);
    range_bad   = ({1'b0, state_a} >= ns_eff) || ({1'b0, state_b} >= ns_eff);
    cat_bad     = (5'(cat_sel) >= nc_eff);

    loc.addr = ADDR_W'((32'(cat_sel) * MAX_STATES + 32'(state_a)) * MAX_STATES
                       + 32'(state_b));

    case (req)
      REQ_ACC: begin
        if (unknown_hit)    loc.status = STAT_UNKNOWN;
        else if (range_bad) loc.status = STAT_RANGE;
        else if (cat_bad)   loc.status = STAT_CATEGORY;
        else                loc.status = STAT_DONE;
      end
      REQ_READ: begin
        if (range_bad)      loc.status = STAT_RANGE;
        else if (cat_bad)   loc.status = STAT_CATEGORY;
        else                loc.status = STAT_DONE;
      end
      default: begin
        loc.status = STAT_DONE;
      end
    endcase
  end

endmodule

// ===== bench/tb_top.sv =====
// Testbench for state_pair_histogram: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import sph_pkg::*;

  // Hold this many quiet cycles after the last result before touching the registers.
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS   = 201;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam logic [WEIGHT_W-1:0]  WEIGHT_MAX       = '1;
  localparam logic [COUNT_W-1:0]   COUNT_MAX        = '1;
  // Category codes that the block folds onto plane zero.
  localparam logic [3:0] CAT_MINUS_ONE = 4'hF;
  localparam logic [3:0] CAT_MOST_NEG  = 4'h8;

  typedef struct packed {
    status_e_t          status;
    logic [COUNT_W-1:0] value;
    logic               saturated;
  } hist_result_t;

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_req_type     = REQ_NOP;
  logic [7:0]            in_state_a      = '0;
  logic [7:0]            in_state_b      = '0;
  logic [WEIGHT_W-1:0]   in_weight       = '0;
  logic signed [3:0]     in_category     = '0;
  logic                  out_valid;
  logic                  out_ready       = 1'b0;
  logic [1:0]            out_status;
  logic [COUNT_W-1:0]    out_entry_value;
  logic                  out_saturated;
  logic                  cfg_valid       = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;

  // Upper bound of the per-transaction wait drawn by both the sender and the receiver.
  int idle_max = 8;
  int error_count = 0;

  // Mirror of the histogram store and its registers, updated at each handshake.
  logic [COUNT_W-1:0] pair_store [ST_DEPTH];
  logic [5:0]         cur_state_count = 6'd4;
  logic [7:0]         cur_unknown     = 8'd255;
  logic [3:0]         cur_num_cats    = 4'd1;

  hist_result_t pending_results [$];

  state_pair_histogram dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_state_a      (in_state_a),
    .in_state_b      (in_state_b),
    .in_weight       (in_weight),
    .in_category     (in_category),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_entry_value (out_entry_value),
    .out_saturated   (out_saturated),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_store();
    foreach (pair_store[i]) pair_store[i] = '0;
  endfunction

  // Registers wider than the store are clamped to the store's dimensions.
  function automatic int active_states();
    return (cur_state_count > MAX_STATES) ? MAX_STATES : int'(cur_state_count);
  endfunction

  function automatic int active_cats();
    return (cur_num_cats > MAX_CATEGORIES) ? MAX_CATEGORIES : int'(cur_num_cats);
  endfunction

  // Range checks shared by accumulate and read; the state check wins over the
  // category check. Entries keep a fixed stride whatever the state count says.
  function automatic status_e_t locate_entry(input logic [7:0] a, input logic [7:0] b,
                                             input logic [3:0] cat_raw,
                                             output logic [ADDR_W-1:0] addr);
    int plane;
    plane = cat_raw[3] ? 0 : int'(cat_raw[2:0]);
    addr  = '0;
    if (a >= active_states() || b >= active_states()) return STAT_RANGE;
    if (plane >= active_cats()) return STAT_CATEGORY;
    addr = ADDR_W'((plane * MAX_STATES + int'(a)) * MAX_STATES + int'(b));
    return STAT_DONE;
  endfunction

  function automatic hist_result_t predict_request(input logic [1:0] req,
                                                   input logic [7:0] a, input logic [7:0] b,
                                                   input logic [WEIGHT_W-1:0] w,
                                                   input logic [3:0] cat);
    hist_result_t      res;
    logic [ADDR_W-1:0] addr;
    logic [COUNT_W:0]  sum;
    res = '0;
    case (req)
      REQ_ACC: begin
        // The unknown code is checked before any range check.
        if (a == cur_unknown || b == cur_unknown) begin
          res.status = STAT_UNKNOWN;
        end else begin
          res.status = locate_entry(a, b, cat, addr);
          if (res.status == STAT_DONE) begin
            sum = {1'b0, pair_store[addr]} + (COUNT_W + 1)'(w);
            if (sum > {1'b0, COUNT_MAX}) begin
              sum           = {1'b0, COUNT_MAX};
              res.saturated = 1'b1;
            end
            pair_store[addr] = sum[COUNT_W-1:0];
            res.value        = sum[COUNT_W-1:0];
          end
        end
      end
      REQ_READ: begin
        // Reads skip the unknown-code check.
        res.status = locate_entry(a, b, cat, addr);
        if (res.status == STAT_DONE) res.value = pair_store[addr];
      end
      REQ_CLEAR: clear_store();
      default: ;
    endcase
    return res;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_STATE_COUNT:    cur_state_count = data[5:0];
      CFG_UNKNOWN_CODE:   cur_unknown     = data;
      CFG_NUM_CATEGORIES: cur_num_cats    = data[3:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard: one block sees every handshake, so the expectation of a
  // transaction is always queued before its result can be taken.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    hist_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (in_valid && in_ready)
        pending_results.push_back(predict_request(in_req_type, in_state_a, in_state_b,
                                                  in_weight, in_category));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %0d value %0d",
                   $time, out_status, out_entry_value);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, out_status);
            error_count++;
          end
          if (out_entry_value !== want.value) begin
            $display("%0t: entry_value mismatch, expected %0d actual %0d",
                     $time, want.value, out_entry_value);
            error_count++;
          end
          if (out_saturated !== want.saturated) begin
            $display("%0t: saturated mismatch, expected %0d actual %0d",
                     $time, want.saturated, out_saturated);
            error_count++;
          end
        end
      end
    end
  end

  // Receiver: draw a stall per result, then hold ready high until a transaction lands.
  initial begin : result_sink
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, idle_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one request transaction. Valid stays high on return, so a back-to-back
  // request just replaces the payload.
  task automatic issue_request(input req_e_t req, input logic [7:0] a, input logic [7:0] b,
                               input logic [WEIGHT_W-1:0] w, input logic [3:0] cat);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_state_a  <= a;
    in_state_b  <= b;
    in_weight   <= w;
    in_category <= cat;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every result is back and the block takes input again;
  // this also rides out the clearing pass after reset.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || !in_ready);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Call only after wait_idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random field pickers: mostly legal values under the current registers, with
  // the unknown code and wild values mixed in.
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick_state();
    int r;
    r = $urandom_range(0, 99);
    if (r < 82 && active_states() > 0) return 8'($urandom_range(0, active_states() - 1));
    if (r < 90) return cur_unknown;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [3:0] pick_category();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80 && active_cats() > 0) return 4'($urandom_range(0, active_cats() - 1));
    if (r < 88) return 4'($urandom_range(8, 15));
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return WEIGHT_W'($urandom_range(0, WEIGHT_MAX));
    if (r < 75) return WEIGHT_W'($urandom_range(0, 15));
    if (r < 85) return WEIGHT_MAX;
    return WEIGHT_W'($urandom_range(0, 4095));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: four states, unknown code 255, one plane. Cover every status
  // code, the check order, negative categories and the unused request code.
  task automatic test_reset_defaults();
    wait_idle();
    issue_request(REQ_READ, 8'd0, 8'd0, '0, 4'd0);
    issue_request(REQ_ACC, 8'd3, 8'd3, WEIGHT_MAX, 4'd0);
    issue_request(REQ_ACC, 8'd3, 8'd3, WEIGHT_MAX, CAT_MINUS_ONE);
    issue_request(REQ_ACC, 8'd3, 8'd3, 20'd1, CAT_MOST_NEG);
    issue_request(REQ_READ, 8'd3, 8'd3, '0, CAT_MINUS_ONE);
    issue_request(REQ_ACC, 8'hFF, 8'd0, 20'd5, 4'd0);
    issue_request(REQ_ACC, 8'd0, 8'hFF, 20'd5, 4'd0);
    issue_request(REQ_ACC, 8'd4, 8'd0, 20'd5, 4'd0);
    issue_request(REQ_ACC, 8'd0, 8'd4, 20'd5, 4'd0);
    issue_request(REQ_ACC, 8'd0, 8'd0, 20'd5, 4'd1);
    issue_request(REQ_ACC, 8'd0, 8'd0, 20'd5, 4'd7);
    // Unknown beats range, range beats category.
    issue_request(REQ_ACC, 8'hFF, 8'd4, 20'd5, 4'd7);
    issue_request(REQ_ACC, 8'd9, 8'd1, 20'd5, 4'd7);
    issue_request(REQ_READ, 8'hFF, 8'hFF, '0, 4'd0);
    issue_request(REQ_READ, 8'd0, 8'd0, '0, 4'd1);
    issue_request(REQ_NOP, 8'hFF, 8'hFF, WEIGHT_MAX, CAT_MINUS_ONE);
    // A read is legal on a state that matches the unknown code.
    wait_idle();
    write_register(CFG_UNKNOWN_CODE, 8'd2);
    issue_request(REQ_READ, 8'd2, 8'd2, '0, 4'd0);
    issue_request(REQ_ACC, 8'd2, 8'd1, 20'd9, 4'd0);
  endtask

  // Registers at and beyond their bounds, zero included.
  task automatic test_register_extremes();
    wait_idle();
    write_register(CFG_STATE_COUNT, 8'd0);
    issue_request(REQ_ACC, 8'd0, 8'd0, 20'd1, 4'd0);
    issue_request(REQ_READ, 8'd0, 8'd0, '0, 4'd0);
    wait_idle();
    write_register(CFG_STATE_COUNT, 8'hFF);
    write_register(CFG_UNKNOWN_CODE, 8'hFF);
    issue_request(REQ_ACC, 8'd31, 8'd31, WEIGHT_MAX, 4'd0);
    issue_request(REQ_ACC, 8'd32, 8'd0, 20'd1, 4'd0);
    issue_request(REQ_READ, 8'd31, 8'd31, '0, 4'd0);
    wait_idle();
    write_register(CFG_NUM_CATEGORIES, 8'd0);
    issue_request(REQ_ACC, 8'd0, 8'd0, 20'd1, 4'd0);
    issue_request(REQ_ACC, 8'd0, 8'd0, 20'd1, CAT_MINUS_ONE);
    wait_idle();
    write_register(CFG_NUM_CATEGORIES, 8'hFF);
    issue_request(REQ_ACC, 8'd5, 8'd6, 20'hABCDE, 4'd7);
    issue_request(REQ_READ, 8'd5, 8'd6, '0, 4'd7);
    wait_idle();
    write_register(CFG_UNKNOWN_CODE, 8'd0);
    write_register(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom_range(0, 255)));
    issue_request(REQ_ACC, 8'd0, 8'd1, 20'd3, 4'd0);
    issue_request(REQ_READ, 8'd0, 8'd0, '0, 4'd0);
    wait_idle();
    write_register(CFG_STATE_COUNT, 8'd2);
    write_register(CFG_UNKNOWN_CODE, 8'hFF);
    issue_request(REQ_ACC, 8'd1, 8'd1, 20'd7, 4'd3);
    issue_request(REQ_ACC, 8'd2, 8'd0, 20'd7, 4'd3);
  endtask

  // Fill a few entries, clear, and read them back as zero.
  task automatic test_clear_store();
    issue_request(REQ_ACC, 8'd0, 8'd1, 20'd100, 4'd0);
    issue_request(REQ_ACC, 8'd1, 8'd0, 20'd200, 4'd7);
    issue_request(REQ_CLEAR, 8'hFF, 8'hFF, WEIGHT_MAX, CAT_MINUS_ONE);
    issue_request(REQ_READ, 8'd0, 8'd1, '0, 4'd0);
    issue_request(REQ_READ, 8'd1, 8'd0, '0, 4'd7);
    issue_request(REQ_READ, 8'd1, 8'd1, '0, 4'd3);
  endtask

  // New register set per phase: the first three pin the extremes, the rest are
  // mostly small state counts so that entries get hit again and again.
  task automatic configure_phase(input int phase);
    logic [5:0] ns;
    logic [3:0] nc;
    logic [7:0] unk;
    logic [1:0] pad_hi;
    logic [3:0] pad_lo;
    case (phase)
      0: begin
        ns = 6'd32;
        nc = 4'd8;
      end
      1: begin
        ns = 6'd63;
        nc = 4'd15;
      end
      2: begin
        ns = 6'd2;
        nc = 4'd1;
      end
      default: begin
        ns = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) :
                                           6'($urandom_range(2, 10));
        nc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
                                           4'($urandom_range(1, 8));
      end
    endcase
    unk    = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 9));
    pad_hi = 2'($urandom_range(0, 3));
    pad_lo = 4'($urandom_range(0, 15));
    wait_idle();
    write_register(CFG_STATE_COUNT, {pad_hi, ns});
    write_register(CFG_UNKNOWN_CODE, unk);
    write_register(CFG_NUM_CATEGORIES, {pad_lo, nc});
  endtask

  // Mostly legal accumulates and reads with random content; one clear per phase.
  // Alternate phases with and without idling on both sides.
  task automatic test_random_traffic();
    int     r;
    req_e_t req;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      configure_phase(phase);
      idle_max = (phase % 2 == 0) ? 8 : 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (k == PHASE_ITEMS / 2) req = REQ_CLEAR;
        else if (r < 3)           req = REQ_NOP;
        else if (r < 65)          req = REQ_ACC;
        else                      req = REQ_READ;
        issue_request(req, pick_state(), pick_state(), pick_weight(), pick_category());
      end
    end
    idle_max = 8;
  endtask

  initial begin
    clear_store();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_clear_store();
    test_random_traffic();
    // Drain, then leave room for any stray result to show up.
    wait_idle();
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: a limit several times the slowest legal run.
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
